// ===== sv/radix2_fft_frame_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// radix2_fft_frame_engine_top_defines
// Assertion macros shared by the FFT frame engine RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_FRAME_ENGINE_TOP_DEFINES_SVH
`define RADIX2_FFT_FRAME_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define R2FFT_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2fft same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define R2FFT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("r2fft next-cycle check failed");

`endif

// ===== sv/r2fft_pkg.sv =====
// ----------------------------------------------------------------------------
// r2fft_pkg
// Sizes, twiddle tables, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package r2fft_pkg;

	localparam int LOG2_POINTS = 10;
	localparam int POINTS      = 1 << LOG2_POINTS;
	localparam int HALF_POINTS = POINTS / 2;
	localparam int QTR_POINTS  = POINTS / 4;

	localparam int IDX_W     = LOG2_POINTS;
	localparam int HALF_W    = LOG2_POINTS - 1;
	localparam int QTR_W     = LOG2_POINTS - 2;
	localparam int STG_W     = $clog2(LOG2_POINTS);
	localparam int SAMPLE_W  = 16;
	localparam int BIN_W     = 27;
	localparam int BIN_IDX_W = 10;
	localparam int TW_W      = 18;
	localparam int PROD_W    = BIN_W + TW_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int FRAC_W    = 16;
	localparam int TR_W      = SUM_W - FRAC_W;
	localparam int BF_W      = TR_W + 1;

	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_PULL = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PULL_WAIT,
		ST_COPY,
		ST_COPY_END,
		ST_BF_RA,
		ST_BF_RB,
		ST_BF_MUL,
		ST_BF_WA,
		ST_BF_WB
	} ctrl_state_t;

	typedef struct packed {
		logic push_wr;
		logic pull_rd;
		logic pull_empty;
		logic pull_load;
		logic copy_rd;
		logic bf_rd_a;
		logic bf_rd_b;
		logic bf_mul;
		logic bf_wr_a;
		logic bf_wr_b;
		logic frame_end;
	} dp_cmd_t;

	typedef struct packed {
		logic push_last;
		logic copy_last;
		logic bf_last;
		logic stage_last;
		logic frame_ready;
		logic out_free;
	} dp_stat_t;

	typedef logic signed [TW_W-1:0] tw_rom_t [QTR_POINTS];

	function automatic logic [63:0] div_term(input logic [63:0] t, input int n,
		input logic odd);
		if (odd) begin
			case (n)
				1: return t / 6;
				2: return t / 20;
				3: return t / 42;
				4: return t / 72;
				5: return t / 110;
				6: return t / 156;
				7: return t / 210;
				8: return t / 272;
				9: return t / 342;
				10: return t / 420;
				11: return t / 506;
				default: return t / 600;
			endcase
		end else begin
			case (n)
				1: return t / 2;
				2: return t / 12;
				3: return t / 30;
				4: return t / 56;
				5: return t / 90;
				6: return t / 132;
				7: return t / 182;
				8: return t / 240;
				9: return t / 306;
				10: return t / 380;
				11: return t / 462;
				default: return t / 552;
			endcase
		end
	endfunction

	// Taylor series of cos or sin on a Q2.30 angle in the first quadrant.
	function automatic logic signed [63:0] series_q30(input logic [63:0] x, input logic odd);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = odd ? x : Q30_ONE;
		sum  = $signed(term);
		for (int n = 1; n <= 12; n++) begin
			term = div_term((term * x2) >> 30, n, odd);
			if ((n % 2) == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return sum;
	endfunction

	function automatic logic signed [TW_W-1:0] q30_to_q16(input logic signed [63:0] v);
		logic [63:0] u;
		u = (v < 0) ? 64'd0 : v;
		u = (u + 64'd8192) >> 14;
		return u[TW_W-1:0];
	endfunction

	function automatic tw_rom_t build_rom(input logic odd);
		tw_rom_t     rom;
		logic [63:0] x;
		for (int q = 0; q < QTR_POINTS; q++) begin
			x      = (TWO_PI_Q30 * 64'(q)) / POINTS;
			rom[q] = q30_to_q16(series_q30(x, odd));
		end
		return rom;
	endfunction

	localparam tw_rom_t COS_ROM = build_rom(1'b0);
	localparam tw_rom_t SIN_ROM = build_rom(1'b1);

	function automatic logic [IDX_W-1:0] bitrev(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] r;
		for (int b = 0; b < IDX_W; b++)
			r[b] = v[IDX_W-1-b];
		return r;
	endfunction

	function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [BF_W-1:0] v);
		if ((&v[BF_W-1:BIN_W-1]) || (~|v[BF_W-1:BIN_W-1]))
			return v[BIN_W-1:0];
		else if (v[BF_W-1])
			return {1'b1, {(BIN_W-1){1'b0}}};
		else
			return {1'b0, {(BIN_W-1){1'b1}}};
	endfunction

endpackage

// ===== sv/radix2_fft_frame_engine_top.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_frame_engine_top
// 1024-point radix-2 DIT FFT frame engine: push samples, pull bins.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  kind, sample_real, sample_imag
//  out      out_valid / out_stall bin_real, bin_imag, bin_index, last_bin, ready_res
//
//  A push yields no result item. A pull reads the work store, then loads the
//  result register; a pull before the first frame loads a zero item with
//  ready_res low without a read of the work store.
//  The final push of a frame starts a copy of the sample store into the work
//  store and then POINTS/2 * LOG2_POINTS butterflies, each in the steps read
//  A, read B, multiply, write A, write B, on the one shared butterfly unit,
//  bounded by the single write port of the work store.
//  in_stall stays high for the whole transform and while a result item waits
//  under out_stall. Reset clears counters and flags, not the stores.
// ----------------------------------------------------------------------------
`include "radix2_fft_frame_engine_top_defines.svh"

module radix2_fft_frame_engine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  kind,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [r2fft_pkg::BIN_W-1:0]    bin_real,
	output logic signed [r2fft_pkg::BIN_W-1:0]    bin_imag,
	output logic [r2fft_pkg::BIN_IDX_W-1:0]       bin_index,
	output logic                                  last_bin,
	output logic                                  ready_res
);
	import r2fft_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	r2fft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	r2fft_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bin_real    (bin_real),
		.bin_imag    (bin_imag),
		.bin_index   (bin_index),
		.last_bin    (last_bin),
		.ready_res   (ready_res)
	);

	// no item is taken while the copy or a butterfly is in flight
	`R2FFT_ASSERT_IMPLY(a_idle_accept, !in_stall,
		!dp_cmd.copy_rd && !dp_cmd.bf_wr_a && !dp_cmd.bf_wr_b && !dp_cmd.pull_load)

	// an early pull delivers an all-zero item
	`R2FFT_ASSERT_NEXT(a_early_pull,
		in_valid && !in_stall && kind == KIND_PULL && !dp_stat.frame_ready,
		out_valid && !ready_res && bin_real == '0 && bin_imag == '0 && bin_index == '0)

	// the last mark follows the bin index
	`R2FFT_ASSERT_IMPLY(a_last_mark, out_valid && ready_res,
		last_bin == (bin_index == BIN_IDX_W'(POINTS - 1)))

endmodule

// ===== sv/r2fft_ram.sv =====
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/r2fft_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: item intake, frame copy and butterfly step control.
// ----------------------------------------------------------------------------
module r2fft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                kind,
	output logic                in_stall,
	input  r2fft_pkg::dp_stat_t stat,
	output r2fft_pkg::dp_cmd_t  cmd
);
	import r2fft_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        accept;

	assign in_stall = !((state_q == ST_IDLE) && stat.out_free);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_PUSH) begin
						if (stat.push_last)
							state_d = ST_COPY;
					end else if (stat.frame_ready) begin
						state_d = ST_PULL_WAIT;
					end
				end
			end
			ST_PULL_WAIT: state_d = ST_IDLE;
			ST_COPY: begin
				if (stat.copy_last)
					state_d = ST_COPY_END;
			end
			ST_COPY_END: state_d = ST_BF_RA;
			ST_BF_RA:    state_d = ST_BF_RB;
			ST_BF_RB:    state_d = ST_BF_MUL;
			ST_BF_MUL:   state_d = ST_BF_WA;
			ST_BF_WA:    state_d = ST_BF_WB;
			ST_BF_WB: begin
				if (stat.bf_last && stat.stage_last)
					state_d = ST_IDLE;
				else
					state_d = ST_BF_RA;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_PUSH)
						cmd.push_wr = 1'b1;
					else if (stat.frame_ready)
						cmd.pull_rd = 1'b1;
					else
						cmd.pull_empty = 1'b1;
				end
			end
			ST_PULL_WAIT: cmd.pull_load = 1'b1;
			ST_COPY:      cmd.copy_rd = 1'b1;
			ST_COPY_END:  cmd = '0;
			ST_BF_RA:     cmd.bf_rd_a = 1'b1;
			ST_BF_RB:     cmd.bf_rd_b = 1'b1;
			ST_BF_MUL:    cmd.bf_mul = 1'b1;
			ST_BF_WA:     cmd.bf_wr_a = 1'b1;
			ST_BF_WB: begin
				cmd.bf_wr_b   = 1'b1;
				cmd.frame_end = stat.bf_last && stat.stage_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/r2fft_dp.sv =====
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample and work stores, shared butterfly, counters and result register.
// ----------------------------------------------------------------------------
module r2fft_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  r2fft_pkg::dp_cmd_t                        cmd,
	output r2fft_pkg::dp_stat_t                       stat,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0]     sample_real,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0]     sample_imag,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [r2fft_pkg::BIN_W-1:0]        bin_real,
	output logic signed [r2fft_pkg::BIN_W-1:0]        bin_imag,
	output logic [r2fft_pkg::BIN_IDX_W-1:0]           bin_index,
	output logic                                      last_bin,
	output logic                                      ready_res
);
	import r2fft_pkg::*;

	// control counters
	logic [IDX_W-1:0]  push_cnt_q, pull_idx_q, copy_cnt_q;
	logic [HALF_W-1:0] bf_cnt_q;
	logic [STG_W-1:0]  stage_q;
	logic              frame_done_q, out_valid_q;
	logic              copy_we_s1;
	logic [IDX_W-1:0]  copy_wa_s1;

	// butterfly registers
	logic signed [BIN_W-1:0]  a_re_q, a_im_q;
	logic signed [TW_W-1:0]   tw_c_q, tw_s_q;
	logic signed [PROD_W-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;

	// store ports
	logic [2*SAMPLE_W-1:0] ld_rd;
	logic [2*BIN_W-1:0]    wk_rd, wk_wd;
	logic [IDX_W-1:0]      wk_ra, wk_wa;
	logic                  wk_we;
	logic signed [BIN_W-1:0]    rd_re, rd_im;
	logic signed [SAMPLE_W-1:0] ld_re, ld_im;

	// address generation
	logic [IDX_W-1:0]  hmask, m_ext, up_addr, lo_addr;
	logic [HALF_W-1:0] tw_k;
	logic [STG_W-1:0]  tw_sh;
	logic [QTR_W-1:0]  tw_q;
	logic signed [TW_W-1:0] tw_c, tw_s;

	// butterfly math
	logic signed [SUM_W-1:0] sum_r, sum_i, rnd_r, rnd_i;
	logic signed [TR_W-1:0]  t_r, t_i;
	logic signed [BIN_W-1:0] up_re, up_im, lo_re, lo_im;

	assign rd_re = wk_rd[2*BIN_W-1:BIN_W];
	assign rd_im = wk_rd[BIN_W-1:0];
	assign ld_re = ld_rd[2*SAMPLE_W-1:SAMPLE_W];
	assign ld_im = ld_rd[SAMPLE_W-1:0];

	assign hmask   = ~({IDX_W{1'b1}} << stage_q);
	assign m_ext   = {1'b0, bf_cnt_q};
	assign up_addr = ((m_ext & ~hmask) << 1) | (m_ext & hmask);
	assign lo_addr = up_addr | (IDX_W'(1) << stage_q);
	assign tw_sh   = STG_W'(LOG2_POINTS - 1) - stage_q;
	assign tw_k    = (bf_cnt_q & hmask[HALF_W-1:0]) << tw_sh;
	assign tw_q    = tw_k[QTR_W-1:0];

	// fold the second quadrant onto the first
	always_comb begin
		if (tw_k[HALF_W-1]) begin
			tw_c = -SIN_ROM[tw_q];
			tw_s = COS_ROM[tw_q];
		end else begin
			tw_c = COS_ROM[tw_q];
			tw_s = SIN_ROM[tw_q];
		end
	end

	// round half up after the Q16 shift
	assign sum_r = SUM_W'(p_rc_q) + SUM_W'(p_is_q);
	assign sum_i = SUM_W'(p_ic_q) - SUM_W'(p_rs_q);
	assign rnd_r = sum_r + SUM_W'(1 << (FRAC_W - 1));
	assign rnd_i = sum_i + SUM_W'(1 << (FRAC_W - 1));
	assign t_r   = rnd_r[SUM_W-1:FRAC_W];
	assign t_i   = rnd_i[SUM_W-1:FRAC_W];
	assign up_re = sat_bin(BF_W'(a_re_q) + BF_W'(t_r));
	assign up_im = sat_bin(BF_W'(a_im_q) + BF_W'(t_i));
	assign lo_re = sat_bin(BF_W'(a_re_q) - BF_W'(t_r));
	assign lo_im = sat_bin(BF_W'(a_im_q) - BF_W'(t_i));

	always_comb begin
		priority if (cmd.pull_rd)
			wk_ra = pull_idx_q;
		else if (cmd.bf_rd_b)
			wk_ra = lo_addr;
		else
			wk_ra = up_addr;
	end

	always_comb begin
		wk_we = copy_we_s1 || cmd.bf_wr_a || cmd.bf_wr_b;
		priority if (copy_we_s1) begin
			wk_wa = copy_wa_s1;
			wk_wd = {BIN_W'(ld_re), BIN_W'(ld_im)};
		end else if (cmd.bf_wr_b) begin
			wk_wa = lo_addr;
			wk_wd = {lo_re, lo_im};
		end else begin
			wk_wa = up_addr;
			wk_wd = {up_re, up_im};
		end
	end

	r2fft_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(POINTS)) u_load_ram (
		.clk     (clk),
		.wr_en   (cmd.push_wr),
		.wr_addr (bitrev(push_cnt_q)),
		.wr_data ({sample_real, sample_imag}),
		.rd_addr (copy_cnt_q),
		.rd_data (ld_rd)
	);

	r2fft_ram #(.WIDTH(2 * BIN_W), .DEPTH(POINTS)) u_work_ram (
		.clk     (clk),
		.wr_en   (wk_we),
		.wr_addr (wk_wa),
		.wr_data (wk_wd),
		.rd_addr (wk_ra),
		.rd_data (wk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_cnt_q   <= '0;
			pull_idx_q   <= '0;
			copy_cnt_q   <= '0;
			bf_cnt_q     <= '0;
			stage_q      <= '0;
			frame_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
			copy_we_s1   <= 1'b0;
		end else begin
			copy_we_s1 <= cmd.copy_rd;
			if (cmd.push_wr)
				push_cnt_q <= push_cnt_q + 1'b1;
			if (cmd.copy_rd)
				copy_cnt_q <= copy_cnt_q + 1'b1;
			if (cmd.bf_wr_b) begin
				bf_cnt_q <= bf_cnt_q + 1'b1;
				if (stat.bf_last)
					stage_q <= stat.stage_last ? '0 : stage_q + 1'b1;
			end
			if (cmd.frame_end) begin
				frame_done_q <= 1'b1;
				pull_idx_q   <= '0;
			end
			if (cmd.pull_load)
				pull_idx_q <= pull_idx_q + 1'b1;
			if (cmd.pull_load || cmd.pull_empty)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		copy_wa_s1 <= copy_cnt_q;
		if (cmd.bf_rd_a) begin
			tw_c_q <= tw_c;
			tw_s_q <= tw_s;
		end
		if (cmd.bf_rd_b) begin
			a_re_q <= rd_re;
			a_im_q <= rd_im;
		end
		if (cmd.bf_mul) begin
			p_rc_q <= rd_re * tw_c_q;
			p_is_q <= rd_im * tw_s_q;
			p_ic_q <= rd_im * tw_c_q;
			p_rs_q <= rd_re * tw_s_q;
		end
		if (cmd.pull_load) begin
			bin_real  <= rd_re;
			bin_imag  <= rd_im;
			bin_index <= BIN_IDX_W'(pull_idx_q);
			last_bin  <= (pull_idx_q == {IDX_W{1'b1}});
			ready_res <= 1'b1;
		end else if (cmd.pull_empty) begin
			bin_real  <= '0;
			bin_imag  <= '0;
			bin_index <= '0;
			last_bin  <= 1'b0;
			ready_res <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.push_last   = (push_cnt_q == {IDX_W{1'b1}});
	assign stat.copy_last   = (copy_cnt_q == {IDX_W{1'b1}});
	assign stat.bf_last     = (bf_cnt_q == {HALF_W{1'b1}});
	assign stat.stage_last  = (stage_q == STG_W'(LOG2_POINTS - 1));
	assign stat.frame_ready = frame_done_q;
	assign stat.out_free    = !out_valid_q || !out_stall;

endmodule
